// File: hdl/patch_zbuffer_visibility_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the patch z-buffer visibility test RTL.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in
// the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PATCH_ZBUFFER_VISIBILITY_TEST_UNIT_DEFINES_SVH
`define PATCH_ZBUFFER_VISIBILITY_TEST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PZVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PZVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pzvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzvt_pkg
// Types and fixed constants of the patch z-buffer visibility test block.
// ----------------------------------------------------------------------------
package pzvt_pkg;

    // Field widths.
    localparam int unsigned DIM_W      = 12;
    localparam int unsigned DEPTH_W    = 16;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned PIX_W      = 22;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned FRAC_W     = 4;
    localparam int unsigned RND_W      = COORD_W + 1 - FRAC_W;
    localparam int unsigned PROD_W     = 2 * DIM_W;
    localparam int unsigned IDX_W      = PROD_W + 1;

    // Map words carry a clear-epoch tag next to the stored depth.
    localparam int unsigned EPOCH_W    = 8;
    localparam int unsigned MAP_WORD_W = EPOCH_W + DEPTH_W;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // One half in Q4.
    localparam logic signed [COORD_W:0] ROUND_HALF = (COORD_W + 1)'(8);

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;

    // Register port.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0] REG_COLOR_WIDTH  = 2'd0;
    localparam logic [1:0] REG_COLOR_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH_TOL    = 2'd2;

    localparam logic [DIM_W-1:0]   COLOR_WIDTH_RST  = 12'd1920;
    localparam logic [DIM_W-1:0]   COLOR_HEIGHT_RST = 12'd1080;
    localparam logic [DEPTH_W-1:0] DEPTH_TOL_RST    = 16'd50;

    typedef struct packed {
        logic [DIM_W-1:0]   color_width;
        logic [DIM_W-1:0]   color_height;
        logic [DEPTH_W-1:0] depth_tolerance;
    } t_cfg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_RMW
    } t_state;

endpackage

// File: hdl/patch_zbuffer_visibility_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_zbuffer_visibility_test_unit
// Patch z-buffer occlusion test between a depth sensor and a color camera.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_valid / o_ready) carries one depth pixel per request:
// a mode, a depth and a Q4 color coordinate. Mode 0 clears the patch map,
// mode 1 folds the depth into the minimum of its patch, mode 2 tests the
// pixel against the stored minimum. Every request yields exactly one result
// on the result channel (o_valid / i_ready).
// A new request is taken only after the previous one has left its map
// write-back: each request walks a sequencer that rounds the coordinate,
// forms the map and pixel indexes with two small multipliers, reads the
// map memory and then writes the updated entry back.
// The map is cleared by tagging each word with a clear epoch, so a clear
// request normally costs no extra time. After reset, and after every 255th
// clear request, a clearing pass over all MAP_ENTRIES words zeroes the tags; the
// request channel stays not ready during it, while register writes proceed.
// When the receiver stalls, the result stays in the output register; the
// next request may be taken and processed up to its map write-back, where it
// waits until the output register frees up.
// ----------------------------------------------------------------------------
module patch_zbuffer_visibility_test_unit import pzvt_pkg::*; #(
    parameter int unsigned MAP_ENTRIES = 131072,
    parameter int unsigned PATCH_SHIFT = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [DEPTH_W-1:0]    i_depth,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    // Result channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_in_range,
    output logic                  o_visible,
    output logic [PIX_W-1:0]      o_pixel_index,
    output logic [DEPTH_W-1:0]    o_patch_depth
);

`include "patch_zbuffer_visibility_test_unit_defines.svh"

    localparam int unsigned ADDR_W = $clog2(MAP_ENTRIES);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAP_ENTRIES - 1);
    localparam logic [IDX_W-1:0]  IDX_LIMIT = IDX_W'(MAP_ENTRIES);

    t_cfg cfg;

    pzvt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer state.
    t_state r_state;
    t_state n_state;

    // Request held for the duration of its processing.
    logic [MODE_W-1:0]       r_mode;
    logic [DEPTH_W-1:0]      r_depth;
    logic signed [RND_W-1:0] r_rx;
    logic signed [RND_W-1:0] r_ry;

    // Products and decoded address.
    logic [PROD_W-1:0] r_prod_map;
    logic [PROD_W-1:0] r_prod_pix;
    logic              r_map_ok;
    logic              r_img_ok;
    logic [ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]  r_pix;

    // Clear bookkeeping.
    logic [EPOCH_W-1:0] r_epoch;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Output register.
    logic               r_out_valid;
    logic               r_out_in_range;
    logic               r_out_visible;
    logic [PIX_W-1:0]   r_out_pix;
    logic [DEPTH_W-1:0] r_out_pdepth;

    // Sequencer outputs.
    logic in_ready;
    logic mem_re;
    logic clr_active;
    logic out_load;

    // Memory port.
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [MAP_WORD_W-1:0] mem_wdata;
    logic [MAP_WORD_W-1:0] mem_rdata;

    // Rounding: add one half in Q4 and drop the fraction bits.
    logic signed [COORD_W:0] sum_x;
    logic signed [COORD_W:0] sum_y;

    assign sum_x = {i_coord_x[COORD_W-1], i_coord_x} + ROUND_HALF;
    assign sum_y = {i_coord_y[COORD_W-1], i_coord_y} + ROUND_HALF;

    // Geometry of the held request. A non-negative rounded value reaches
    // 2048 at most, so it fits the low DIM_W + 1 bits.
    logic [DIM_W:0]   x;
    logic [DIM_W:0]   y;
    logic [DIM_W:0]   px;
    logic [DIM_W:0]   py;
    logic [DIM_W-1:0] map_w;
    logic [DIM_W-1:0] map_h;
    logic             neg;
    logic [IDX_W-1:0] idx;

    assign x     = r_rx[DIM_W:0];
    assign y     = r_ry[DIM_W:0];
    assign px    = x >> PATCH_SHIFT;
    assign py    = y >> PATCH_SHIFT;
    assign map_w = cfg.color_width >> PATCH_SHIFT;
    assign map_h = cfg.color_height >> PATCH_SHIFT;
    assign neg   = r_rx[RND_W-1] || r_ry[RND_W-1];
    assign idx   = IDX_W'(r_prod_map) + IDX_W'(px);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_ADDR;
            S_ADDR: n_state = S_RMW;
            S_RMW: begin
                if (out_load) begin
                    if (r_mode == MODE_CLEAR && r_epoch == EPOCH_LAST) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready   = 1'b0;
        mem_re     = 1'b0;
        clr_active = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_CLEAR: clr_active = 1'b1;
            S_IDLE:  in_ready   = 1'b1;
            S_ADDR:  mem_re     = 1'b1;
            S_RMW:   out_load   = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    assign o_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture and address generation.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_mode  <= i_mode;
            r_depth <= i_depth;
            r_rx    <= sum_x[COORD_W:FRAC_W];
            r_ry    <= sum_y[COORD_W:FRAC_W];
        end
        if (r_state == S_CALC) begin
            r_prod_map <= PROD_W'(py) * PROD_W'(map_w);
            r_prod_pix <= PROD_W'(y) * PROD_W'(cfg.color_width);
        end
        if (r_state == S_ADDR) begin
            r_map_ok <= !neg && (px < {1'b0, map_w}) && (py < {1'b0, map_h}) &&
                        (idx < IDX_LIMIT);
            r_img_ok <= !neg && (x < {1'b0, cfg.color_width}) &&
                        (y < {1'b0, cfg.color_height});
            r_addr   <= idx[ADDR_W-1:0];
            r_pix    <= PIX_W'(r_prod_pix + PROD_W'(x));
        end
    end

    // Read-modify-write. A word belongs to the current map only when its
    // tag matches the current epoch; any other word reads as empty.
    logic [EPOCH_W-1:0] rd_tag;
    logic [DEPTH_W-1:0] rd_dep;
    logic [DEPTH_W-1:0] old;
    logic               upd;
    logic [DEPTH_W-1:0] acc_val;
    logic [DEPTH_W-1:0] diff;
    logic               res_in_range;
    logic               res_visible;
    logic [PIX_W-1:0]   res_pix;
    logic [DEPTH_W-1:0] res_pdepth;

    assign rd_tag  = mem_rdata[MAP_WORD_W-1 -: EPOCH_W];
    assign rd_dep  = mem_rdata[DEPTH_W-1:0];
    assign old     = (r_map_ok && rd_tag == r_epoch) ? rd_dep : '0;
    assign upd     = (old == '0) || (old > r_depth);
    assign acc_val = upd ? r_depth : old;
    assign diff    = (r_depth >= old) ? (r_depth - old) : (old - r_depth);

    always_comb begin
        res_in_range = 1'b0;
        res_visible  = 1'b0;
        res_pix      = '0;
        res_pdepth   = '0;
        case (r_mode)
            MODE_ACCUM: begin
                res_in_range = r_map_ok;
                res_pdepth   = r_map_ok ? acc_val : '0;
            end
            MODE_TEST: begin
                res_in_range = r_img_ok;
                res_visible  = r_img_ok && (diff < cfg.depth_tolerance);
                res_pix      = r_img_ok ? r_pix : '0;
                res_pdepth   = r_img_ok ? old : '0;
            end
            default: ;
        endcase
    end

    assign mem_we    = clr_active ||
                       (out_load && r_mode == MODE_ACCUM && r_map_ok && upd);
    assign mem_waddr = clr_active ? r_clr_addr : r_addr;
    assign mem_wdata = clr_active ? '0 : {r_epoch, r_depth};

    // The map is read in the address cycle straight from the freshly formed
    // index, so the word is there when the write-back cycle starts.
    pzvt_map_mem #(
        .DEPTH  (MAP_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_map_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // Epoch and clearing pass. The epoch moves on with every clear request;
    // when it runs out, the sweep zeroes all tags and the epoch restarts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= EPOCH_FIRST;
            r_clr_addr <= '0;
        end else if (clr_active) begin
            if (r_clr_addr == CLR_LAST) begin
                r_clr_addr <= '0;
                r_epoch    <= EPOCH_FIRST;
            end else begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end else if (out_load && r_mode == MODE_CLEAR && r_epoch != EPOCH_LAST) begin
            r_epoch <= r_epoch + EPOCH_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_in_range <= res_in_range;
            r_out_visible  <= res_visible;
            r_out_pix      <= res_pix;
            r_out_pdepth   <= res_pdepth;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_in_range    = r_out_in_range;
    assign o_visible     = r_out_visible;
    assign o_pixel_index = r_out_pix;
    assign o_patch_depth = r_out_pdepth;

    // Checks.
    `PZVT_ASSERT_NEXT(a_accept_starts_calc, in_ready && i_valid, r_state == S_CALC,
        "accepted request did not start address calculation")
    `PZVT_ASSERT_NOW(a_write_phase, mem_we, r_state == S_RMW || r_state == S_CLEAR,
        "map written outside write-back or clearing pass")
    `PZVT_ASSERT_NOW(a_write_is_accum, mem_we && r_state == S_RMW,
        r_mode == MODE_ACCUM && r_map_ok, "write-back for a request that may not write")
    `PZVT_ASSERT_NEXT(a_hold_on_stall, r_state == S_RMW && r_out_valid && !i_ready,
        r_state == S_RMW, "write-back left while the output register was full")

endmodule

// File: hdl/pzvt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzvt_cfg_regs
// Register file for image size and depth tolerance behind an APB-style port.
// ----------------------------------------------------------------------------
module pzvt_cfg_regs import pzvt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_width     <= COLOR_WIDTH_RST;
            r_cfg.color_height    <= COLOR_HEIGHT_RST;
            r_cfg.depth_tolerance <= DEPTH_TOL_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_COLOR_WIDTH:  r_cfg.color_width     <= pwdata[DIM_W-1:0];
                REG_COLOR_HEIGHT: r_cfg.color_height    <= pwdata[DIM_W-1:0];
                REG_DEPTH_TOL:    r_cfg.depth_tolerance <= pwdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COLOR_WIDTH:  prdata = APB_DATA_W'(r_cfg.color_width);
            REG_COLOR_HEIGHT: prdata = APB_DATA_W'(r_cfg.color_height);
            REG_DEPTH_TOL:    prdata = APB_DATA_W'(r_cfg.depth_tolerance);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: hdl/pzvt_map_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzvt_map_mem
// Patch map storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module pzvt_map_mem import pzvt_pkg::*; #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [MAP_WORD_W-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [MAP_WORD_W-1:0] o_rdata
);

    logic [MAP_WORD_W-1:0] r_mem [DEPTH];
    logic [MAP_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
